[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/tfuc_pkg.sv]
// Package with constants, palette and controller/datapath types of the upscaler.
package tfuc_pkg;

    localparam int DEF_FRAME_ROWS = 24;
    localparam int DEF_FRAME_COLS = 32;

    // Bilinear weights in 512ths and the final shift.
    localparam int WGT_ONE  = 512;
    localparam int WGT_STEP = 102;
    localparam int SUB_N    = 5;
    localparam int ACC_SHIFT = 18;

    // Normalization offsets.
    localparam int T_OFS  = 400;
    localparam int HI_OFS = 390;
    localparam int LO_OFS = 430;
    localparam int SPAN_OFS = 40;
    localparam int LEVEL_MAX = 255;

    localparam int OP_LOAD   = 0;
    localparam int OP_RENDER = 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       cell_cap;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       p_cap;
        logic [1:0] p_sel;
        logic       mul_en;
        logic [2:0] mul_step;
        logic       div_init;
        logic       div_en;
        logic [2:0] div_bit;
        logic [2:0] sx;
        logic [2:0] sy;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_ready;
    } t_sts;

    localparam logic [15:0] HEAT_PALETTE [256] = '{
        16'h0000,16'h0000,16'h0000,16'h0001,16'h0001,16'h0002,16'h0002,16'h0003,
        16'h0003,16'h0004,16'h0004,16'h0005,16'h0005,16'h0006,16'h0006,16'h0007,
        16'h0007,16'h0008,16'h0008,16'h0009,16'h0009,16'h000A,16'h000A,16'h000B,
        16'h000B,16'h000C,16'h000C,16'h000D,16'h000D,16'h000E,16'h000E,16'h000F,
        16'h000F,16'h000F,16'h0010,16'h0010,16'h0011,16'h0011,16'h0012,16'h0012,
        16'h0013,16'h0013,16'h0014,16'h0014,16'h0015,16'h0015,16'h0016,16'h0016,
        16'h0017,16'h0017,16'h0018,16'h0018,16'h0019,16'h0019,16'h001A,16'h001A,
        16'h001B,16'h001B,16'h001C,16'h001C,16'h001D,16'h001D,16'h001E,16'h001E,
        16'h001E,16'h001E,16'h003D,16'h005D,16'h007C,16'h009C,16'h00BB,16'h00DB,
        16'h00FA,16'h011A,16'h0139,16'h0159,16'h0178,16'h0198,16'h01B7,16'h01D7,
        16'h01F6,16'h0216,16'h0235,16'h0255,16'h0274,16'h0294,16'h02B3,16'h02D3,
        16'h02F2,16'h0312,16'h0331,16'h0351,16'h0370,16'h0390,16'h03AF,16'h03CF,
        16'h03EF,16'h040E,16'h042E,16'h044D,16'h046D,16'h048C,16'h04AC,16'h04CB,
        16'h04EB,16'h050A,16'h052A,16'h0549,16'h0569,16'h0588,16'h05A8,16'h05C7,
        16'h05E7,16'h0606,16'h0626,16'h0645,16'h0665,16'h0684,16'h06A4,16'h06C3,
        16'h06E3,16'h0702,16'h0722,16'h0741,16'h0761,16'h0780,16'h07A0,16'h07C0,
        16'h07E0,16'h07E0,16'h07E0,16'h0FE0,16'h0FE0,16'h17E0,16'h17E0,16'h1FE0,
        16'h1FE0,16'h27E0,16'h27E0,16'h2FE0,16'h2FE0,16'h37E0,16'h37E0,16'h3FE0,
        16'h3FE0,16'h47E0,16'h47E0,16'h4FE0,16'h4FE0,16'h57E0,16'h57E0,16'h5FE0,
        16'h5FE0,16'h67E0,16'h67E0,16'h6FE0,16'h6FE0,16'h77E0,16'h77E0,16'h7FE0,
        16'h7FE0,16'h7FE0,16'h87E0,16'h87E0,16'h8FE0,16'h8FE0,16'h97E0,16'h97E0,
        16'h9FE0,16'h9FE0,16'hA7E0,16'hA7E0,16'hAFE0,16'hAFE0,16'hB7E0,16'hB7E0,
        16'hBFE0,16'hBFE0,16'hC7E0,16'hC7E0,16'hCFE0,16'hCFE0,16'hD7E0,16'hD7E0,
        16'hDFE0,16'hDFE0,16'hE7E0,16'hE7E0,16'hEFE0,16'hEFE0,16'hF7E0,16'hF7E0,
        16'hFFC0,16'hFFA0,16'hFF80,16'hFF60,16'hFF40,16'hFF20,16'hFF00,16'hFEE0,
        16'hFEC0,16'hFEA0,16'hFE80,16'hFE60,16'hFE40,16'hFE20,16'hFE00,16'hFDE0,
        16'hFDC0,16'hFDA0,16'hFD80,16'hFD60,16'hFD40,16'hFD20,16'hFD00,16'hFCE0,
        16'hFCC0,16'hFCA0,16'hFC80,16'hFC60,16'hFC40,16'hFC20,16'hFC00,16'hFBE0,
        16'hFBC0,16'hFBA0,16'hFB80,16'hFB60,16'hFB40,16'hFB20,16'hFB00,16'hFAE0,
        16'hFAC0,16'hFAA0,16'hFA80,16'hFA60,16'hFA40,16'hFA20,16'hFA00,16'hF9E0,
        16'hF9C0,16'hF9A0,16'hF980,16'hF960,16'hF940,16'hF920,16'hF900,16'hF8E0,
        16'hF8C0,16'hF8A0,16'hF880,16'hF860,16'hF840,16'hF820,16'hF800,16'hF800
    };

endpackage

[hw/rtl/tfuc_if.sv]
// Handshake interfaces for the input, result and configuration channels.
interface tfuc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] pixel_value;
    logic [4:0]  cell_row;
    logic [4:0]  cell_col;
    modport source (output valid, op, pixel_value, cell_row, cell_col, input ready);
    modport sink (input valid, op, pixel_value, cell_row, cell_col, output ready);
endinterface

interface tfuc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] color;
    logic [7:0]  level;
    logic [15:0] interp_value;
    logic [2:0]  sub_x;
    logic [2:0]  sub_y;
    logic        last;
    logic [15:0] frame_max;
    logic [15:0] frame_min;
    logic [15:0] center_value;
    modport source (output valid, color, level, interp_value, sub_x, sub_y, last,
                    frame_max, frame_min, center_value, input ready);
    modport sink (input valid, color, level, interp_value, sub_x, sub_y, last,
                  frame_max, frame_min, center_value, output ready);
endinterface

interface tfuc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[hw/rtl/tfuc_datapath.sv]
// Datapath: frame memory, frame statistics, shared multiplier and level divider.
`include "assert_macros.svh"
module tfuc_datapath #(
    parameter int FRAME_ROWS = tfuc_pkg::DEF_FRAME_ROWS,
    parameter int FRAME_COLS = tfuc_pkg::DEF_FRAME_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tfuc_pkg::t_cmd     i_cmd,
    input  logic [15:0]        i_pixel_value,
    input  logic [4:0]         i_cell_row,
    input  logic [4:0]         i_cell_col,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output tfuc_pkg::t_sts     o_sts,
    output logic [7:0]         o_level,
    output logic [15:0]        o_interp_value,
    output logic [15:0]        o_frame_max,
    output logic [15:0]        o_frame_min,
    output logic [15:0]        o_center_value
);
    import tfuc_pkg::*;

    localparam int PIXELS = FRAME_ROWS * FRAME_COLS;
    localparam int RW = $clog2(FRAME_ROWS);
    localparam int CW = $clog2(FRAME_COLS);
    localparam int AW = $clog2(PIXELS);
    localparam int CR0 = FRAME_ROWS / 2;
    localparam int CR1 = (FRAME_ROWS / 2 + 1 < FRAME_ROWS) ? FRAME_ROWS / 2 + 1
                                                            : FRAME_ROWS - 1;
    localparam int CC0 = FRAME_COLS / 2 - 1;
    localparam int CC1 = FRAME_COLS / 2;

    logic [15:0]   mem [PIXELS];
    logic [15:0]   r_rd;
    logic [15:0]   r_offset;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [15:0]   r_run_max, r_run_min, r_stat_max, r_stat_min, r_stat_center;
    logic [17:0]   r_csum;
    logic          r_ready;
    logic [RW-1:0] r_crow;
    logic [CW-1:0] r_ccol;
    logic [15:0]   r_p [4];
    logic [34:0]   r_acc;
    logic [24:0]   r_h0, r_h1;
    logic [15:0]   r_val;
    logic [24:0]   r_rem;
    logic [16:0]   r_den;
    logic [7:0]    r_q;

    // Load path: offset, mirrored address and statistics update.
    logic [15:0]   v;
    logic [CW-1:0] s;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_w, wc_w;
    logic [2:0]    cw;
    logic [17:0]   n_csum;
    logic [15:0]   n_max, n_min;
    logic          frame_end;

    always_comb begin
        v        = i_pixel_value + r_offset;
        s        = CW'(FRAME_COLS - 1) - r_col;
        wr_addr  = AW'(r_row) * AW'(FRAME_COLS) + AW'(s);
        wr_w     = 2'((32'(r_row) == CR0) ? 1 : 0) + 2'((32'(r_row) == CR1) ? 1 : 0);
        wc_w     = 2'((32'(s) == CC0) ? 1 : 0) + 2'((32'(s) == CC1) ? 1 : 0);
        cw       = 3'(wr_w * wc_w);
        n_csum   = r_csum + 18'(v) * 18'(cw);
        n_max    = (v > r_run_max) ? v : r_run_max;
        n_min    = (v < r_run_min) ? v : r_run_min;
        frame_end = (32'(r_row) == FRAME_ROWS - 1) && (32'(r_col) == FRAME_COLS - 1);
    end

    // Frame memory: one write port for loads, one registered read port for renders.
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] base;
    always_comb begin
        base = AW'(r_crow) * AW'(FRAME_COLS) + AW'(r_ccol);
        case (i_cmd.rd_sel)
            2'd0:    rd_addr = base;
            2'd1:    rd_addr = base + AW'(1);
            2'd2:    rd_addr = base + AW'(FRAME_COLS);
            default: rd_addr = base + AW'(FRAME_COLS + 1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[wr_addr] <= v;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Configuration register, load counters and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset      <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_run_max     <= '0;
            r_run_min     <= 16'hFFFF;
            r_stat_max    <= '0;
            r_stat_min    <= '0;
            r_stat_center <= '0;
            r_csum        <= '0;
            r_ready       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (frame_end) begin
                    r_stat_max    <= n_max;
                    r_stat_min    <= n_min;
                    r_stat_center <= n_csum[17:2];
                    r_run_max     <= '0;
                    r_run_min     <= 16'hFFFF;
                    r_csum        <= '0;
                    r_row         <= '0;
                    r_col         <= '0;
                    r_ready       <= 1'b1;
                end else begin
                    r_run_max <= n_max;
                    r_run_min <= n_min;
                    r_csum    <= n_csum;
                    if (32'(r_col) == FRAME_COLS - 1) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
            end
        end
    end

    // Cell capture with saturation, and pixel capture from the read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_cap) begin
            r_crow <= RW'((32'(i_cell_row) > FRAME_ROWS - 2) ? FRAME_ROWS - 2
                                                             : 32'(i_cell_row));
            r_ccol <= CW'((32'(i_cell_col) > FRAME_COLS - 2) ? FRAME_COLS - 2
                                                             : 32'(i_cell_col));
        end
        if (i_cmd.p_cap) begin
            r_p[i_cmd.p_sel] <= r_rd;
        end
    end

    // Shared multiplier: horizontal blend of both rows, then vertical blend.
    logic [9:0]  wx1, wx0, wy1, wy0, mb;
    logic [24:0] ma;
    logic [34:0] n_acc;
    always_comb begin
        wx1 = 10'(i_cmd.sx) * 10'(WGT_STEP);
        wx0 = 10'(WGT_ONE) - wx1;
        wy1 = 10'(i_cmd.sy) * 10'(WGT_STEP);
        wy0 = 10'(WGT_ONE) - wy1;
        case (i_cmd.mul_step)
            3'd0:    ma = 25'(r_p[0]);
            3'd1:    ma = 25'(r_p[1]);
            3'd2:    ma = 25'(r_p[2]);
            3'd3:    ma = 25'(r_p[3]);
            3'd4:    ma = r_h0;
            default: ma = r_h1;
        endcase
        if (i_cmd.mul_step[2]) begin
            mb = i_cmd.mul_step[0] ? wy1 : wy0;
        end else begin
            mb = i_cmd.mul_step[0] ? wx1 : wx0;
        end
        n_acc = (i_cmd.mul_step[0] ? r_acc : 35'd0) + 35'(ma) * 35'(mb);
    end

    // Normalization: clamp against the latched range and set up the division.
    logic signed [17:0] t_raw, t_hi, t_lo, t_c;
    logic [15:0]        val;
    logic [16:0]        num;
    always_comb begin
        val   = r_acc[ACC_SHIFT +: 16];
        t_raw = $signed({2'b00, val}) - 18'sd400;
        t_hi  = $signed({2'b00, r_stat_max}) - 18'(HI_OFS);
        t_lo  = $signed({2'b00, r_stat_min}) - 18'(LO_OFS);
        t_c   = (t_raw > t_hi) ? t_hi : t_raw;
        t_c   = (t_c < t_lo) ? t_lo : t_c;
        num   = 17'(t_c - t_lo);
    end

    // Restoring divider, one quotient bit per cycle.
    logic [24:0] dsh;
    assign dsh = 25'(r_den) << i_cmd.div_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_acc <= n_acc;
            if (i_cmd.mul_step == 3'd1) begin
                r_h0 <= n_acc[24:0];
            end
            if (i_cmd.mul_step == 3'd3) begin
                r_h1 <= n_acc[24:0];
            end
        end
        if (i_cmd.div_init) begin
            r_val <= val;
            r_rem <= 25'(num) * 25'(LEVEL_MAX);
            r_den <= 17'(r_stat_max) - 17'(r_stat_min) + 17'(SPAN_OFS);
            r_q   <= '0;
        end else if (i_cmd.div_en) begin
            if (r_rem >= dsh) begin
                r_rem <= r_rem - dsh;
                r_q[i_cmd.div_bit] <= 1'b1;
            end
        end
    end

    assign o_sts.frame_ready = r_ready;
    assign o_level           = r_q;
    assign o_interp_value    = r_val;
    assign o_frame_max       = r_stat_max;
    assign o_frame_min       = r_stat_min;
    assign o_center_value    = r_stat_center;

    `ASSERT_CLK(a_stat_order, r_ready |-> (r_stat_max >= r_stat_min), "frame max below min")
    `ASSERT_CLK(a_col_range, 32'(r_col) < FRAME_COLS, "load column out of range")
    `ASSERT_CLK(a_num_range, i_cmd.div_init |=> (r_rem <= 25'(r_den) * 25'(LEVEL_MAX)), "level above 255")
endmodule

[hw/rtl/tfuc_ctrl.sv]
// Controller: sequences memory reads, multiplies, division and result output.
`include "assert_macros.svh"
module tfuc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_last,
    input  tfuc_pkg::t_sts i_sts,
    output tfuc_pkg::t_cmd o_cmd
);
    import tfuc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_DIVP, ST_DIV, ST_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [2:0] r_sx, n_sx, r_sy, n_sy;
    logic       acc_in;

    assign acc_in      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_last      = (32'(r_sx) == SUB_N - 1) && (32'(r_sy) == SUB_N - 1);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sx    = r_sx;
        n_sy    = r_sy;
        o_cmd   = '0;
        o_cmd.sx       = r_sx;
        o_cmd.sy       = r_sy;
        o_cmd.rd_sel   = r_cnt[1:0];
        o_cmd.p_sel    = 2'(r_cnt - 3'd1);
        o_cmd.mul_step = r_cnt;
        o_cmd.div_bit  = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    if (i_in_op == 1'(OP_LOAD)) begin
                        o_cmd.load = 1'b1;
                    end else if (i_sts.frame_ready) begin
                        o_cmd.cell_cap = 1'b1;
                        n_state = ST_READ;
                        n_cnt   = '0;
                        n_sx    = '0;
                        n_sy    = '0;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = (r_cnt < 3'd4);
                o_cmd.p_cap = (r_cnt != 3'd0);
                if (r_cnt == 3'd4) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_cnt == 3'd5) begin
                    n_state = ST_DIVP;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_DIVP: begin
                o_cmd.div_init = 1'b1;
                n_state = ST_DIV;
                n_cnt   = 3'd7;
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                if (r_cnt == 3'd0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_cnt = '0;
                    if (o_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MUL;
                        if (32'(r_sx) == SUB_N - 1) begin
                            n_sx = '0;
                            n_sy = r_sy + 3'd1;
                        end else begin
                            n_sx = r_sx + 3'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
        end
    end

    `ASSERT_CLK(a_last_idle, (o_out_valid && i_out_ready && o_last) |=> (r_state == ST_IDLE), "no return to idle")
    `ASSERT_CLK(a_one_cmd, $onehot0({o_cmd.load, o_cmd.cell_cap, o_cmd.mul_en, o_cmd.div_init, o_cmd.div_en}), "overlapping commands")
    `ASSERT_NEVER(a_sub_range, (32'(r_sx) >= SUB_N) || (32'(r_sy) >= SUB_N), "sub-pixel out of range")
endmodule

[hw/rtl/thermal_frame_upscale_colormap.sv]
// Top level of the thermal frame upscaler with false-color palette.
// A load word is taken while idle and the block stays ready for the next word.
// A render word reads its four pixels through the read port of the frame memory, then
// produces each of the 25 sub-pixels in turn: 6 passes through the shared multiplier, a
// setup state, the 8 quotient bits of the bit-serial level divider and an output state
// that waits while the result side holds ready low. One render is in flight at a time;
// the input side is not ready until its 25th word has been taken. Renders are ignored
// until a full frame has been loaded. No memory clearing runs after reset.
module thermal_frame_upscale_colormap #(
    parameter int FRAME_ROWS = tfuc_pkg::DEF_FRAME_ROWS,
    parameter int FRAME_COLS = tfuc_pkg::DEF_FRAME_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfuc_in_if.sink     i_in,
    tfuc_out_if.source  o_out,
    tfuc_cfg_if.sink    i_cfg
);
    import tfuc_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] level;
    logic       last;

    tfuc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_last      (last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tfuc_datapath #(
        .FRAME_ROWS (FRAME_ROWS),
        .FRAME_COLS (FRAME_COLS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_pixel_value  (i_in.pixel_value),
        .i_cell_row     (i_in.cell_row),
        .i_cell_col     (i_in.cell_col),
        .i_cfg_we       (i_cfg.valid && i_cfg.ready),
        .i_cfg_data     (i_cfg.data),
        .o_sts          (sts),
        .o_level        (level),
        .o_interp_value (o_out.interp_value),
        .o_frame_max    (o_out.frame_max),
        .o_frame_min    (o_out.frame_min),
        .o_center_value (o_out.center_value)
    );

    // The configuration register is always writable.
    assign i_cfg.ready = 1'b1;

    // Result word fields.
    assign o_out.level = level;
    assign o_out.color = HEAT_PALETTE[level];
    assign o_out.sub_x = cmd.sx;
    assign o_out.sub_y = cmd.sy;
    assign o_out.last  = last;
endmodule

[verif/thermal_frame_upscale_colormap_tb.sv]
// Self-checking testbench for the thermal frame upscaler with its false-color palette.
module thermal_frame_upscale_colormap_tb;
    import tfuc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = DEF_FRAME_ROWS;
    localparam int COLS = DEF_FRAME_COLS;
    localparam int PIXELS = ROWS * COLS;
    localparam int IDLE_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 450;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  level;
        logic [15:0] interp_value;
        logic [2:0]  sub_x;
        logic [2:0]  sub_y;
        logic        last;
        logic [15:0] frame_max;
        logic [15:0] frame_min;
        logic [15:0] center_value;
    } t_subpix;

    logic i_clk;
    logic i_rst_n;

    tfuc_in_if  in_ch();
    tfuc_out_if out_ch();
    tfuc_cfg_if cfg_ch();

    thermal_frame_upscale_colormap u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Shadow copy of the block state.
    logic [15:0] shadow_frame [PIXELS];
    int unsigned load_pos;
    logic [15:0] run_max;
    logic [15:0] run_min;
    logic [17:0] ctr_sum;
    logic [15:0] lat_max;
    logic [15:0] lat_min;
    logic [15:0] lat_center;
    bit          have_frame;
    logic [15:0] offset_reg;

    t_subpix     expected_pixels[$];
    int          fail_count = 0;
    int          burst_left;
    bit          hold_req;
    int          idle_cycles = 0;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predict one load word.
    function automatic void predict_load(logic [15:0] raw);
        int unsigned r;
        int unsigned s;
        int unsigned wr;
        int unsigned wc;
        int unsigned r1;
        logic [15:0] v;
        r = load_pos / COLS;
        s = COLS - 1 - (load_pos % COLS);
        v = raw + offset_reg;
        r1 = (ROWS / 2 + 1 < ROWS) ? ROWS / 2 + 1 : ROWS - 1;
        wr = (r == ROWS / 2) + (r == r1);
        wc = (s == COLS / 2 - 1) + (s == COLS / 2);
        shadow_frame[r * COLS + s] = v;
        if (v > run_max) run_max = v;
        if (v < run_min) run_min = v;
        ctr_sum = ctr_sum + 18'(v * wr * wc);
        if (load_pos + 1 >= PIXELS) begin
            lat_max = run_max;
            lat_min = run_min;
            lat_center = 16'(ctr_sum / 4);
            run_max = '0;
            run_min = '1;
            ctr_sum = '0;
            load_pos = 0;
            have_frame = 1'b1;
        end else begin
            load_pos++;
        end
    endfunction

    // Predict the 25 sub-pixels of one cell.
    function automatic void predict_render(logic [4:0] row_in, logic [4:0] col_in);
        int unsigned row;
        int unsigned col;
        int unsigned base;
        longint unsigned p00, p01, p10, p11, wx0, wx1, wy0, wy1, acc;
        longint hi, lo, t;
        longint unsigned lvl;
        t_subpix sp;
        if (!have_frame) return;
        row = (row_in > ROWS - 2) ? ROWS - 2 : row_in;
        col = (col_in > COLS - 2) ? COLS - 2 : col_in;
        base = row * COLS + col;
        p00 = shadow_frame[base];
        p01 = shadow_frame[base + 1];
        p10 = shadow_frame[base + COLS];
        p11 = shadow_frame[base + COLS + 1];
        hi = longint'(lat_max) - HI_OFS;
        lo = longint'(lat_min) - LO_OFS;
        for (int y = 0; y < SUB_N; y++) begin
            wy1 = y * WGT_STEP;
            wy0 = WGT_ONE - wy1;
            for (int x = 0; x < SUB_N; x++) begin
                wx1 = x * WGT_STEP;
                wx0 = WGT_ONE - wx1;
                acc = p00 * wx0 * wy0 + p10 * wx0 * wy1 + p01 * wx1 * wy0 + p11 * wx1 * wy1;
                sp.interp_value = 16'(acc >> ACC_SHIFT);
                t = longint'(sp.interp_value) - T_OFS;
                if (t > hi) t = hi;
                if (t < lo) t = lo;
                lvl = longint'(t - lo) * LEVEL_MAX / longint'(hi - lo);
                if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
                sp.level = 8'(lvl);
                sp.color = HEAT_PALETTE[sp.level];
                sp.sub_x = 3'(x);
                sp.sub_y = 3'(y);
                sp.last = (x == SUB_N - 1) && (y == SUB_N - 1);
                sp.frame_max = lat_max;
                sp.frame_min = lat_min;
                sp.center_value = lat_center;
                expected_pixels.push_back(sp);
            end
        end
    endfunction

    // Send one word, with bursts and random gaps between them.
    task automatic send_word(logic op, logic [15:0] pix, logic [4:0] crow, logic [4:0] ccol);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.pixel_value <= pix;
        in_ch.cell_row <= crow;
        in_ch.cell_col <= ccol;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (op == 1'(OP_LOAD)) predict_load(pix);
        else predict_render(crow, ccol);
    endtask

    task automatic load_word(logic [15:0] pix);
        send_word(1'(OP_LOAD), pix, 5'($urandom), 5'($urandom));
    endtask

    task automatic render_word(logic [4:0] crow, logic [4:0] ccol);
        send_word(1'(OP_RENDER), 16'($urandom), crow, ccol);
    endtask

    // Stop sending and wait for every result, then for the block to settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        offset_reg = value;
    endtask

    // Renders sent before any full frame are dropped.
    task automatic test_render_without_frame();
        write_offset(16'h0000);
        render_word(5'd0, 5'd0);
        load_word(16'h1234);
        render_word(5'd22, 5'd30);
        drain();
    endtask

    // Complete the frame begun above with extreme pixels, then render corner cells
    // and saturating cell coordinates.
    task automatic test_extremes();
        write_offset(16'hFFFF);
        for (int i = 1; i < PIXELS; i++) begin
            case (i % 4)
                0: load_word(16'h0000);
                1: load_word(16'hFFFF);
                2: load_word(16'h0001);
                default: load_word(16'($urandom));
            endcase
        end
        render_word(5'd0, 5'd0);
        render_word(5'd22, 5'd30);
        render_word(5'd31, 5'd31);
        render_word(5'd23, 5'd0);
        render_word(5'd11, 5'd15);
        render_word(5'd12, 5'd16);
        drain();
    endtask

    // Reload the first rows with one flat value and render there, then render
    // across the edge of the partly reloaded frame.
    task automatic test_flat_and_partial();
        write_offset(16'h0190);
        for (int i = 0; i < 2 * COLS; i++) load_word(16'h0000);
        render_word(5'd0, 5'd0);
        for (int i = 0; i < COLS; i++) load_word(16'($urandom_range(0, 2000)));
        render_word(5'd1, 5'd3);
        render_word(5'd20, 5'd3);
        drain();
    endtask

    // The result side holds off while words keep coming.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) render_word(5'($urandom), 5'($urandom));
        drain();
        hold_req = 1'b0;
    endtask

    // Random loads with renders mixed in, then a run of random renders.
    task automatic test_random_mix();
        write_offset(16'($urandom));
        for (int i = 0; i < 48; i++) begin
            load_word(16'($urandom));
            if ($urandom_range(0, 99) < 20) render_word(5'($urandom), 5'($urandom));
        end
        for (int i = 0; i < 12; i++) render_word(5'($urandom), 5'($urandom));
        drain();
    endtask

    // Receiver: stall pattern of its own, plus one long hold-off on request.
    always @(posedge i_clk) begin
        static int phase = 0;
        static int hold_cnt = 0;
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt++;
            out_ch.ready <= 1'b0;
        end else begin
            if (!hold_req) begin
                hold_cnt = 0;
            end
            phase = (phase + 1) % 64;
            if (phase < 16) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Compare each accepted sub-pixel with the oldest expected one.
    always @(posedge i_clk) begin
        t_subpix e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_pixels.size() == 0) begin
                $error("Unexpected result word");
                fail_count++;
            end else begin
                e = expected_pixels.pop_front();
                check_field("color", e.color, out_ch.color);
                check_field("level", e.level, out_ch.level);
                check_field("interp_value", e.interp_value, out_ch.interp_value);
                check_field("sub_x", e.sub_x, out_ch.sub_x);
                check_field("sub_y", e.sub_y, out_ch.sub_y);
                check_field("last", e.last, out_ch.last);
                check_field("frame_max", e.frame_max, out_ch.frame_max);
                check_field("frame_min", e.frame_min, out_ch.frame_min);
                check_field("center_value", e.center_value, out_ch.center_value);
            end
        end
    end

    // Watchdog on cycles with no accepted word anywhere.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.pixel_value = '0;
        in_ch.cell_row = '0;
        in_ch.cell_col = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        burst_left = 0;
        hold_req = 1'b0;
        load_pos = 0;
        run_max = '0;
        run_min = '1;
        ctr_sum = '0;
        lat_max = '0;
        lat_min = '0;
        lat_center = '0;
        have_frame = 1'b0;
        offset_reg = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_render_without_frame();
        test_extremes();
        test_flat_and_partial();
        test_backpressure();
        test_random_mix();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tfuc_pkg.sv
hw/rtl/tfuc_if.sv
hw/rtl/tfuc_datapath.sv
hw/rtl/tfuc_ctrl.sv
hw/rtl/thermal_frame_upscale_colormap.sv
verif/thermal_frame_upscale_colormap_tb.sv
